>>> src/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring buffer
// Command and status codes, the decoded operation type and the request
// record that travels from the front end to the execution back end.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;

    // command codes at the input port
    localparam logic [2:0] CMD_RESET   = 3'd0;
    localparam logic [2:0] CMD_OPEN    = 3'd1;
    localparam logic [2:0] CMD_PUSH    = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_PEEK    = 3'd4;
    localparam logic [2:0] CMD_CONSUME = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_COMMITTED = 2'd3;

    typedef enum logic [2:0] {
        OP_RESET,
        OP_OPEN,
        OP_OPEN_EMPTY,
        OP_PUSH,
        OP_READ,
        OP_PEEK,
        OP_CONSUME,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] length;
        logic [7:0]  data_byte;
        logic [9:0]  read_index;
    } t_req;

endpackage

>>> src/byte_ring_fifo_atomic_push_core.sv
// An input transfer is registered in the request queue, then executed by the
// execution stage that loads the output register.
// Throughput: one item per cycle unless the output channel stalls; set by the
// single execution stage and its one write and one read port on the byte store.
// Reset: synchronous, active low; clears counters, request queue and output
// valid flag. The byte store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// byte_ring_fifo_atomic_push_core: ring buffer with atomic record push
// Front end classifies commands, a two-entry queue decouples it from the
// back end that owns the byte store and the ring counters.
// ----------------------------------------------------------------------------
module byte_ring_fifo_atomic_push_core #(
    parameter int unsigned CAPACITY = brf_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_data_byte,
    input  logic [9:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_read_data,
    output logic [9:0]  o_read_offset,
    output logic [10:0] o_contiguous_count,
    output logic [10:0] o_used_count,
    output logic [10:0] o_free_count,
    output logic [31:0] o_drop_count,
    output logic [63:0] o_bytes_dropped,
    output logic [10:0] o_high_water
);

    brf_pkg::t_req s_front_req;
    brf_pkg::t_req s_q_req;
    logic          s_push;
    logic          s_pop;
    logic          s_q_full;
    logic          s_q_nempty;

    brf_front u_front (
        .i_valid      (i_in_valid),
        .i_command    (i_command),
        .i_length     (i_length),
        .i_data_byte  (i_data_byte),
        .i_read_index (i_read_index),
        .i_q_full     (s_q_full),
        .o_ready      (o_in_ready),
        .o_push       (s_push),
        .o_req        (s_front_req)
    );

    brf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_req    (s_front_req),
        .i_pop    (s_pop),
        .o_full   (s_q_full),
        .o_nempty (s_q_nempty),
        .o_req    (s_q_req)
    );

    brf_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (s_q_nempty),
        .i_req              (s_q_req),
        .o_pop              (s_pop),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_read_data        (o_read_data),
        .o_read_offset      (o_read_offset),
        .o_contiguous_count (o_contiguous_count),
        .o_used_count       (o_used_count),
        .o_free_count       (o_free_count),
        .o_drop_count       (o_drop_count),
        .o_bytes_dropped    (o_bytes_dropped),
        .o_high_water       (o_high_water)
    );

endmodule

>>> src/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front: input front end
// Takes input transfers while the request queue has room and classifies the
// command into an operation for the back end.
// ----------------------------------------------------------------------------
module brf_front (
    input  logic          i_valid,
    input  logic [2:0]    i_command,
    input  logic [31:0]   i_length,
    input  logic [7:0]    i_data_byte,
    input  logic [9:0]    i_read_index,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output brf_pkg::t_req o_req
);

    brf_pkg::t_op s_op;

    always_comb begin
        case (i_command)
            brf_pkg::CMD_RESET:   s_op = brf_pkg::OP_RESET;
            // a zero-length open is a no-op, flag it here
            brf_pkg::CMD_OPEN:    s_op = (i_length == 32'd0) ? brf_pkg::OP_OPEN_EMPTY
                                                             : brf_pkg::OP_OPEN;
            brf_pkg::CMD_PUSH:    s_op = brf_pkg::OP_PUSH;
            brf_pkg::CMD_READ:    s_op = brf_pkg::OP_READ;
            brf_pkg::CMD_PEEK:    s_op = brf_pkg::OP_PEEK;
            brf_pkg::CMD_CONSUME: s_op = brf_pkg::OP_CONSUME;
            default:              s_op = brf_pkg::OP_BAD;
        endcase
    end

    assign o_ready          = !i_q_full;
    assign o_push           = i_valid && !i_q_full;
    assign o_req.op         = s_op;
    assign o_req.length     = i_length;
    assign o_req.data_byte  = i_data_byte;
    assign o_req.read_index = i_read_index;

endmodule

>>> src/brf_queue.sv
// ----------------------------------------------------------------------------
// brf_queue: request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module brf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brf_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nempty,
    output brf_pkg::t_req o_req
);

    brf_pkg::t_req r_slot [2];
    logic          r_wp;
    logic          n_wp;
    logic          r_rp;
    logic          n_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = i_pop  ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_req;
        end
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_req    = r_slot[r_rp];

endmodule

>>> src/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back: execution back end
// Holds the byte store and the ring counters, carries out one request per
// cycle unless the output channel stalls, and registers each result for it.
// ----------------------------------------------------------------------------
module brf_back #(
    parameter int unsigned CAPACITY = brf_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  brf_pkg::t_req i_req,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    output logic [7:0]    o_read_data,
    output logic [9:0]    o_read_offset,
    output logic [10:0]   o_contiguous_count,
    output logic [10:0]   o_used_count,
    output logic [10:0]   o_free_count,
    output logic [31:0]   o_drop_count,
    output logic [63:0]   o_bytes_dropped,
    output logic [10:0]   o_high_water
);

    localparam int          ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [31:0] CAP32  = 32'(CAPACITY);

    logic [7:0] r_store [CAPACITY];

    logic [31:0] r_wc,    n_wc;
    logic [31:0] r_rc,    n_rc;
    logic        r_ro,    n_ro;
    logic [31:0] r_rt,    n_rt;
    logic [31:0] r_rw,    n_rw;
    logic [31:0] r_drops, n_drops;
    logic [63:0] r_dtot,  n_dtot;
    logic [31:0] r_peak,  n_peak;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [1:0]  r_status;
    logic        r_is_read;
    logic [9:0]  r_roff;
    logic [10:0] r_contig;
    logic [10:0] r_used;
    logic [10:0] r_free;
    logic [7:0]  r_rdq;

    logic              s_pop;
    logic [31:0]       s_stored;
    logic [31:0]       s_free;
    logic [31:0]       s_idx;
    logic [31:0]       s_rw_inc;
    logic [31:0]       s_now;
    logic [31:0]       s_roff;
    logic [31:0]       s_contig;
    logic [31:0]       s_used_n;
    logic [31:0]       s_wr_pos;
    logic [31:0]       s_rd_pos;
    logic              s_wr_en;
    logic              s_rd_en;
    logic              s_is_read;
    logic [1:0]        s_status;

    // advance only when the output register is free or being emptied
    assign s_pop    = i_req_valid && (!r_out_valid || i_out_ready);
    assign o_pop    = s_pop;
    assign s_stored = r_wc - r_rc;
    assign s_free   = CAP32 - s_stored;
    assign s_idx    = 32'(i_req.read_index);
    assign s_rw_inc = r_rw + 32'd1;
    assign s_wr_pos = r_wc + r_rw;
    assign s_rd_pos = r_rc + s_idx;

    always_comb begin
        n_wc      = r_wc;
        n_rc      = r_rc;
        n_ro      = r_ro;
        n_rt      = r_rt;
        n_rw      = r_rw;
        n_drops   = r_drops;
        n_dtot    = r_dtot;
        n_peak    = r_peak;
        s_status  = brf_pkg::ST_OK;
        s_wr_en   = 1'b0;
        s_rd_en   = 1'b0;
        s_is_read = 1'b0;
        s_roff    = 32'd0;
        s_contig  = 32'd0;
        s_now     = s_stored + r_rt;
        if (s_pop) begin
            case (i_req.op)
                brf_pkg::OP_RESET: begin
                    n_wc    = 32'd0;
                    n_rc    = 32'd0;
                    n_ro    = 1'b0;
                    n_rt    = 32'd0;
                    n_rw    = 32'd0;
                    n_drops = 32'd0;
                    n_dtot  = 64'd0;
                    n_peak  = 32'd0;
                end
                brf_pkg::OP_OPEN: begin
                    if (i_req.length > s_free) begin
                        // abandon any open record and count the drop
                        n_ro     = 1'b0;
                        n_drops  = r_drops + 32'd1;
                        n_dtot   = r_dtot + 64'(i_req.length);
                        s_status = brf_pkg::ST_NO_SPACE;
                    end else begin
                        n_ro = 1'b1;
                        n_rt = i_req.length;
                        n_rw = 32'd0;
                    end
                end
                brf_pkg::OP_OPEN_EMPTY: begin
                end
                brf_pkg::OP_PUSH: begin
                    if (!r_ro) begin
                        s_status = brf_pkg::ST_BAD;
                    end else begin
                        s_wr_en = 1'b1;
                        n_rw    = s_rw_inc;
                        if (s_rw_inc == r_rt) begin
                            // commit the whole record at once
                            n_wc     = r_wc + r_rt;
                            n_ro     = 1'b0;
                            n_rt     = 32'd0;
                            n_rw     = 32'd0;
                            s_status = brf_pkg::ST_COMMITTED;
                            if (s_now > r_peak) begin
                                n_peak = s_now;
                            end
                        end
                    end
                end
                brf_pkg::OP_READ: begin
                    if (s_idx >= s_stored) begin
                        s_status = brf_pkg::ST_BAD;
                    end else begin
                        s_rd_en   = 1'b1;
                        s_is_read = 1'b1;
                    end
                end
                brf_pkg::OP_PEEK: begin
                    if (s_stored != 32'd0) begin
                        s_roff   = 32'(r_rc[ADDR_W-1:0]);
                        s_contig = CAP32 - 32'(r_rc[ADDR_W-1:0]);
                        if (s_contig > s_stored) begin
                            s_contig = s_stored;
                        end
                    end
                end
                brf_pkg::OP_CONSUME: begin
                    if (i_req.length > s_stored) begin
                        s_status = brf_pkg::ST_BAD;
                    end else begin
                        n_rc = r_rc + i_req.length;
                    end
                end
                default: begin
                    s_status = brf_pkg::ST_BAD;
                end
            endcase
        end
        s_used_n = n_wc - n_rc;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc        <= 32'd0;
            r_rc        <= 32'd0;
            r_ro        <= 1'b0;
            r_rt        <= 32'd0;
            r_rw        <= 32'd0;
            r_drops     <= 32'd0;
            r_dtot      <= 64'd0;
            r_peak      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wc        <= n_wc;
            r_rc        <= n_rc;
            r_ro        <= n_ro;
            r_rt        <= n_rt;
            r_rw        <= n_rw;
            r_drops     <= n_drops;
            r_dtot      <= n_dtot;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with each executed request
    always_ff @(posedge i_clk) begin
        if (s_pop) begin
            r_status  <= s_status;
            r_is_read <= s_is_read;
            r_roff    <= s_roff[9:0];
            r_contig  <= s_contig[10:0];
            r_used    <= s_used_n[10:0];
            r_free    <= 11'(CAP32 - s_used_n);
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_store[s_wr_pos[ADDR_W-1:0]] <= i_req.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rd_en) begin
            r_rdq <= r_store[s_rd_pos[ADDR_W-1:0]];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_read_data        = r_is_read ? r_rdq : 8'd0;
    assign o_read_offset      = r_roff;
    assign o_contiguous_count = r_contig;
    assign o_used_count       = r_used;
    assign o_free_count       = r_free;
    assign o_drop_count       = r_drops;
    assign o_bytes_dropped    = r_dtot;
    assign o_high_water       = r_peak[10:0];

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wc - r_rc) <= CAP32)
        else $error("stored byte count exceeds capacity");

    a_record_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ro |-> (r_rw < r_rt))
        else $error("open record has written all of its bytes");

    a_peak_covers_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= (r_wc - r_rc))
        else $error("high-water mark below stored count");

    a_reset_cmd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && i_req.op == brf_pkg::OP_RESET) |=>
            (r_wc == 32'd0 && r_rc == 32'd0 && !r_ro && r_drops == 32'd0))
        else $error("reset command left counters set");
`endif

endmodule
